@@ design/s2c_pkg.sv @@
package s2c_pkg;

  localparam int unsigned LonW   = 32;
  localparam int unsigned LatW   = 32;
  localparam int unsigned HgtW   = 40;
  localparam int unsigned CoordW = 41;
  localparam int unsigned RadW   = 34;
  localparam int unsigned InW    = 104;
  localparam int unsigned OutW   = 128;

  // CORDIC datapath word, Q58 fixed point
  localparam int unsigned CordW  = 64;

  localparam int unsigned CordicStagesDef = 32;
  localparam int unsigned AngleBitsDef    = 32;

  localparam logic [RadW-1:0] RadReset = 34'd6378137000;

  localparam logic [63:0] Pi4Q58    = 64'h03243F6A8885A309;
  localparam logic [33:0] PiQ32     = 34'h3243F6A89;
  localparam logic [63:0] Rsqrt2Q64 = 64'hB504F333F9DE6484;
  localparam logic [63:0] OneQ62    = 64'h4000000000000000;

  typedef logic signed [CordW-1:0] cord_t;

  // (a*b + half) >> s, full 128-bit product, low 64 bits kept
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    full = full + (128'd1 << (s - 1));
    full = full >> s;
    return full[63:0];
  endfunction

  // atan(2^-i) in Q58 from the odd power series, evaluated at elaboration
  function automatic logic [63:0] atan_q58(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    sum = '0;
    if (i == 0) begin
      return Pi4Q58;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      if ((2 * k + 1) * i <= 62) begin
        term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + 64'd8) >> 4;
  endfunction

  // CORDIC gain compensation 1/prod(sqrt(1+2^-2i)) in Q58
  function automatic logic [63:0] gain_q58(input int unsigned stages);
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] a;
    int unsigned s;
    logic        done;
    p = OneQ62;
    for (int unsigned i = 1; i < stages; i++) begin
      s = 2 * i;
      if (s <= 62) begin
        f    = OneQ62;
        a    = OneQ62;
        done = 1'b0;
        for (int unsigned n = 1; n < 64; n++) begin
          if (!done) begin
            a = ((a >> s) * 64'(2 * n - 1)) / 64'(2 * n);
            if (a == 64'd0) begin
              done = 1'b1;
            end else if (n[0]) begin
              f = f - a;
            end else begin
              f = f + a;
            end
          end
        end
        p = mul_shr(p, f, 62);
      end
    end
    p = mul_shr(Rsqrt2Q64, p, 64);
    return (p + 64'd8) >> 4;
  endfunction

endpackage

@@ design/s2c_cordic.sv @@
module s2c_cordic #(
  parameter int unsigned CORDIC_STAGES = s2c_pkg::CordicStagesDef,
  parameter int unsigned ANGLE_BITS    = s2c_pkg::AngleBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [31:0]                 ang_i,
  output s2c_pkg::cord_t              sin_o,
  output s2c_pkg::cord_t              cos_o
);
  import s2c_pkg::*;

  localparam logic [31:0] Keep = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [63:0] Gain = gain_q58(CORDIC_STAGES);
  localparam logic signed [32:0] Quarter = 33'sd1073741824;
  localparam logic signed [32:0] Half    = 33'sd2147483648;

  logic signed [32:0] ang_ext;
  logic signed [32:0] ared_d, ared_q;
  logic               flip_d;
  logic [30:0]        mag;
  logic [64:0]        prod_full;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic [63:0]        zmag;

  cord_t x_q [1:CORDIC_STAGES];
  cord_t y_q [1:CORDIC_STAGES];
  cord_t z_q [0:CORDIC_STAGES-1];
  logic  flip_q [1:CORDIC_STAGES+3];
  cord_t sin_q, cos_q;

  // fold angles beyond a quarter turn by half a turn, negate results later
  always_comb begin
    ang_ext = signed'({ang_i[31], ang_i & Keep});
    ared_d  = ang_ext;
    flip_d  = 1'b0;
    if (ang_ext > Quarter) begin
      ared_d = ang_ext - Half;
      flip_d = 1'b1;
    end else if (ang_ext < -Quarter) begin
      ared_d = ang_ext + Half;
      flip_d = 1'b1;
    end
  end

  assign mag       = ared_q[32] ? 31'(-ared_q) : ared_q[30:0];
  assign prod_full = 65'(mag) * 65'(PiQ32);
  assign zmag      = (prod_q + 64'd16) >> 5;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ared_q    <= ared_d;
      flip_q[1] <= flip_d;
      neg_q     <= ared_q[32];
      prod_q    <= prod_full[63:0];
      flip_q[2] <= flip_q[1];
      z_q[0]    <= neg_q ? -signed'(zmag) : signed'(zmag);
      flip_q[3] <= flip_q[2];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [63:0] Atan = atan_q58(i);
    cord_t xi, yi;
    if (i == 0) begin : g_first
      assign xi = signed'(Gain);
      assign yi = '0;
    end else begin : g_rest
      assign xi = x_q[i];
      assign yi = y_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+4] <= flip_q[i+3];
        if (!z_q[i][CordW-1]) begin
          x_q[i+1] <= xi - (yi >>> i);
          y_q[i+1] <= yi + (xi >>> i);
        end else begin
          x_q[i+1] <= xi + (yi >>> i);
          y_q[i+1] <= yi - (xi >>> i);
        end
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1] <= z_q[i][CordW-1] ? z_q[i] + signed'(Atan) : z_q[i] - signed'(Atan);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= flip_q[CORDIC_STAGES+3] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
      cos_q <= flip_q[CORDIC_STAGES+3] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ design/spherical_to_cartesian_core.sv @@
// Spherical to cartesian converter.
// Input words on s_axis carry longitude, latitude (signed binary angles,
// full scale = pi) and height in millimetres. The radius register on the
// cfg port is added to the height; change it only while the block is idle.
// Output words on m_axis carry x = r*cos(lat)*sin(lon), y = r*sin(lat) and
// z = r*cos(lat)*cos(lon), rounded to the nearest millimetre.
// The datapath is the CORDIC pipeline (one stage per rotation plus
// four for angle folding and sign) followed by two chained pairs of
// multipliers of four stages each, built from 22x30-bit partial
// products, and then the output register.
// Throughput: one word per cycle while s_axis_tready is high.
// Reset clears all valid bits and loads the default WGS84 radius.
// When m_axis stalls, the output register holds its word; the pipeline keeps
// advancing and taking input until a finished word reaches its last stage,
// then s_axis_tready drops until the output is taken.
module spherical_to_cartesian_core #(
  parameter int unsigned CORDIC_STAGES = s2c_pkg::CordicStagesDef,
  parameter int unsigned ANGLE_BITS    = s2c_pkg::AngleBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [s2c_pkg::RadW-1:0]    cfg_wdata_i,   // sphere_radius
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [s2c_pkg::InW-1:0]     s_axis_tdata,  // longitude, latitude, height
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [s2c_pkg::OutW-1:0]    m_axis_tdata   // x_coord, y_coord, z_coord, zero pad
);
  import s2c_pkg::*;

  localparam int unsigned Lc = CORDIC_STAGES + 4;
  localparam int unsigned N  = Lc + 8;
  localparam logic [104:0] Round = 105'd1 << 57;

  logic [RadW-1:0]    radius_q;
  logic               pipe_en;
  logic               v_q [1:N];
  logic signed [40:0] r_d;
  logic signed [40:0] r_q [1:Lc];
  cord_t              slon, clon, slat, clat;
  cord_t              sl_q [1:4];
  cord_t              cl_q [1:4];
  logic signed [43:0] yd_q [1:4];
  logic signed [43:0] ma_in [0:3];
  cord_t              mt_in [0:3];
  logic signed [43:0] mres [0:3];
  logic               out_v_q;
  logic [CoordW-1:0]  x_q, y_q, z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // advance unless a finished word would overrun a held output
  assign pipe_en       = m_axis_tready || !out_v_q || !v_q[N];
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j <= N; j++) begin
        v_q[j] <= 1'b0;
      end
    end else if (pipe_en) begin
      v_q[1] <= s_axis_tvalid;
      for (int j = 2; j <= N; j++) begin
        v_q[j] <= v_q[j-1];
      end
    end
  end

  assign r_d = signed'(41'(radius_q)) + 41'(signed'(s_axis_tdata[103:64]));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r_q[1] <= r_d;
      for (int j = 2; j <= Lc; j++) begin
        r_q[j] <= r_q[j-1];
      end
      sl_q[1] <= slon;
      cl_q[1] <= clon;
      yd_q[1] <= mres[1];
      for (int j = 2; j <= 4; j++) begin
        sl_q[j] <= sl_q[j-1];
        cl_q[j] <= cl_q[j-1];
        yd_q[j] <= yd_q[j-1];
      end
    end
  end

  s2c_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_cordic_lon (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .ang_i (s_axis_tdata[31:0]),
    .sin_o (slon),
    .cos_o (clon)
  );

  s2c_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_cordic_lat (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .ang_i (s_axis_tdata[63:32]),
    .sin_o (slat),
    .cos_o (clat)
  );

  // first pair: rc = r*cos(lat), y = r*sin(lat); second pair scales rc
  assign ma_in[0] = 44'(r_q[Lc]);
  assign ma_in[1] = 44'(r_q[Lc]);
  assign ma_in[2] = mres[0];
  assign ma_in[3] = mres[0];
  assign mt_in[0] = clat;
  assign mt_in[1] = slat;
  assign mt_in[2] = sl_q[4];
  assign mt_in[3] = cl_q[4];

  for (genvar g = 0; g < 4; g++) begin : g_mul
    logic         neg1_q, neg2_q, neg3_q;
    logic [43:0]  ma_q;
    logic [59:0]  mt_q;
    logic [51:0]  p00_q, p01_q, p10_q, p11_q;
    logic [104:0] slo_q, shi_q;
    logic [104:0] total;
    logic [46:0]  mag;
    logic signed [43:0] res_q;

    assign total = slo_q + (shi_q << 22);
    assign mag   = total[104:58];

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        neg1_q <= ma_in[g][43] ^ mt_in[g][CordW-1];
        ma_q   <= ma_in[g][43] ? 44'(-ma_in[g]) : 44'(ma_in[g]);
        mt_q   <= mt_in[g][CordW-1] ? 60'(-mt_in[g]) : 60'(mt_in[g]);
        neg2_q <= neg1_q;
        p00_q  <= 52'(ma_q[21:0])  * 52'(mt_q[29:0]);
        p01_q  <= 52'(ma_q[21:0])  * 52'(mt_q[59:30]);
        p10_q  <= 52'(ma_q[43:22]) * 52'(mt_q[29:0]);
        p11_q  <= 52'(ma_q[43:22]) * 52'(mt_q[59:30]);
        neg3_q <= neg2_q;
        slo_q  <= 105'(p00_q) + (105'(p01_q) << 30) + Round;
        shi_q  <= 105'(p10_q) + (105'(p11_q) << 30);
        res_q  <= neg3_q ? -signed'(mag[43:0]) : signed'(mag[43:0]);
      end
    end

    assign mres[g] = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (m_axis_tready || !out_v_q) begin
      out_v_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_v_q) begin
      x_q <= mres[2][CoordW-1:0];
      y_q <= yd_q[4][CoordW-1:0];
      z_q <= mres[3][CoordW-1:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, z_q, y_q, x_q};

  a_stall_needed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && v_q[N]) |-> !s_axis_tready)
    else $error("input not stalled while a finished word is blocked");

  a_no_false_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v_q[N]))
    else $error("output valid without a word in the last stage");

endmodule
